// ===== design/wft_pkg.sv =====
`default_nettype none
package wft_pkg;

  // Table geometry
  localparam int TABLE_WORDS = 256;
  localparam int WORD_BYTES  = 16;
  localparam int TOP_RANKS   = 10;

  localparam int ADDR_W = $clog2(TABLE_WORDS);
  localparam int WORD_W = WORD_BYTES * 8;
  localparam int LEN_W  = $clog2(WORD_BYTES + 1);
  localparam int CNT_W  = $clog2(TABLE_WORDS + 1);
  localparam int RANK_W = $clog2(TOP_RANKS);
  localparam int ROW_W  = CNT_W + LEN_W + WORD_W;
  localparam int KEY_W  = CNT_W + WORD_W + LEN_W + ADDR_W;

  // Operation codes
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_END   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // One table row: count, length, zero-padded bytes (byte 0 in the top bits)
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] bytes;
  } row_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    row_t              wdata;
    logic [ADDR_W-1:0] raddr;
  } tbl_req_t;

endpackage
`default_nettype wire

// ===== design/wft_table.sv =====
`default_nettype none
module wft_table
  import wft_pkg::*;
(
  input  wire logic     clk,
  input  wire tbl_req_t req,
  output row_t          rdata
);

  row_t mem [TABLE_WORDS];

  // Write one row, read one row with registered data
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule
`default_nettype wire

// ===== design/word_frequency_top_k.sv =====
`default_nettype none
// Word frequency counter with top-ten ranking. Commands enter on start while busy is low.
// A clear, or a text byte other than a space or newline, is taken without leaving idle. A
// word end (space) flushes the word: stored words are searched one by one, each read and
// then compared, and a new row is added when the word is new. An end command (or newline)
// flushes the word the same way, then ranks by selection: one pass over all n distinct
// words per rank, each read and then compared, with the pick recorded after each pass, for
// m = min(n,10) ranks, all through the single table read port and two key comparators. A
// read keeps busy high for one cycle and returns its result right after, with done high
// for exactly one cycle; it cannot be stalled, so sample the result when done is high.
module word_frequency_top_k
  import wft_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] op,
  input  wire logic [7:0] text_byte,
  input  wire logic [3:0] rank,
  input  wire logic [3:0] char_pos,
  output logic            done,
  output logic            valid_res,
  output logic [8:0]      distinct_words,
  output logic [8:0]      entry_count,
  output logic [4:0]      entry_length,
  output logic [7:0]      entry_byte
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_FIN       = 4'd1;
  localparam logic [3:0] S_SRCH_RD   = 4'd2;
  localparam logic [3:0] S_SRCH_CMP  = 4'd3;
  localparam logic [3:0] S_ADD       = 4'd4;
  localparam logic [3:0] S_SORT_INIT = 4'd5;
  localparam logic [3:0] S_SORT_RD   = 4'd6;
  localparam logic [3:0] S_SORT_CMP  = 4'd7;
  localparam logic [3:0] S_SORT_NEXT = 4'd8;
  localparam logic [3:0] S_RD_OUT    = 4'd9;

  logic [3:0]        state;
  logic [WORD_W-1:0] cur_word;
  logic [LEN_W-1:0]  cur_len;
  logic [CNT_W-1:0]  distinct;
  logic [CNT_W-1:0]  words;
  logic              sorted;
  logic              do_sort;
  logic [ADDR_W-1:0] idx;
  logic [RANK_W-1:0] r;
  logic              have_best;
  logic [KEY_W-1:0]  best_key;
  logic [ADDR_W-1:0] best_idx;
  logic [KEY_W-1:0]  prev_key;
  logic [ADDR_W-1:0] top [TOP_RANKS];
  logic [3:0]        rd_pos;
  logic              rd_ok;

  tbl_req_t          req;
  row_t              rdata;
  logic [7:0]        low_byte;
  logic              match;
  logic              last_idx;
  logic [KEY_W-1:0]  key_i;
  logic              cand;
  logic [RANK_W:0]   nsel;
  logic              rank_ok;
  logic [3:0]        wr_slot;

  wft_table u_table (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  assign busy = (state != S_IDLE);

  // Lower case letters
  always_comb begin
    if (text_byte inside {[8'h41:8'h5A]}) begin
      low_byte = text_byte + 8'h20;
    end else begin
      low_byte = text_byte;
    end
  end

  assign wr_slot  = cur_len[3:0];
  assign match    = (rdata.len == cur_len) && (rdata.bytes == cur_word);
  assign last_idx = (({1'b0, idx} + CNT_W'(1)) == distinct);

  // Rank key: smaller key ranks first
  assign key_i = {~rdata.count, rdata.bytes, rdata.len, idx};
  assign cand  = ((r == '0) || (prev_key < key_i)) && (!have_best || (key_i < best_key));
  assign nsel  = (distinct < CNT_W'(TOP_RANKS)) ? distinct[RANK_W:0] : (RANK_W+1)'(TOP_RANKS);

  assign rank_ok = sorted && ({5'd0, rank} < distinct) && (rank < 4'(TOP_RANKS));

  // Table port control
  always_comb begin
    req.we    = 1'b0;
    req.waddr = idx;
    req.wdata = '{count: rdata.count + CNT_W'(1), len: cur_len, bytes: cur_word};
    req.raddr = idx;
    case (state)
      S_IDLE: begin
        req.raddr = (rank < 4'(TOP_RANKS)) ? top[rank[RANK_W-1:0]] : '0;
      end
      S_SRCH_CMP: begin
        req.we = match;
      end
      S_ADD: begin
        req.we    = 1'b1;
        req.waddr = distinct[ADDR_W-1:0];
        req.wdata = '{count: CNT_W'(1), len: cur_len, bytes: cur_word};
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cur_word <= '0;
      cur_len  <= '0;
      distinct <= '0;
      words    <= '0;
      sorted   <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (op)
              OP_BYTE: begin
                if (text_byte == CH_NEWLINE) begin
                  do_sort <= 1'b1;
                  state   <= S_FIN;
                end else begin
                  sorted <= 1'b0;
                  if (text_byte == CH_SPACE) begin
                    do_sort <= 1'b0;
                    state   <= S_FIN;
                  end else if (cur_len < LEN_W'(WORD_BYTES)) begin
                    cur_word[(WORD_BYTES-1-wr_slot)*8 +: 8] <= low_byte;
                    cur_len <= cur_len + LEN_W'(1);
                  end
                end
              end
              OP_END: begin
                do_sort <= 1'b1;
                state   <= S_FIN;
              end
              OP_READ: begin
                rd_pos <= char_pos;
                rd_ok  <= rank_ok;
                state  <= S_RD_OUT;
              end
              OP_CLEAR: begin
                cur_word <= '0;
                cur_len  <= '0;
                distinct <= '0;
                words    <= '0;
                sorted   <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        // Flush the pending word
        S_FIN: begin
          if (cur_len == '0) begin
            state <= do_sort ? S_SORT_INIT : S_IDLE;
          end else if (words >= CNT_W'(TABLE_WORDS)) begin
            cur_len  <= '0;
            cur_word <= '0;
            state    <= do_sort ? S_SORT_INIT : S_IDLE;
          end else begin
            words <= words + CNT_W'(1);
            idx   <= '0;
            state <= (distinct == '0) ? S_ADD : S_SRCH_RD;
          end
        end
        S_SRCH_RD: begin
          state <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          if (match) begin
            cur_len  <= '0;
            cur_word <= '0;
            state    <= do_sort ? S_SORT_INIT : S_IDLE;
          end else if (last_idx) begin
            state <= S_ADD;
          end else begin
            idx   <= idx + ADDR_W'(1);
            state <= S_SRCH_RD;
          end
        end
        S_ADD: begin
          distinct <= distinct + CNT_W'(1);
          cur_len  <= '0;
          cur_word <= '0;
          state    <= do_sort ? S_SORT_INIT : S_IDLE;
        end
        // Select the best entry ranked after the previous pick, once per rank
        S_SORT_INIT: begin
          r         <= '0;
          idx       <= '0;
          have_best <= 1'b0;
          if (distinct == '0) begin
            sorted <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_SORT_RD;
          end
        end
        S_SORT_RD: begin
          state <= S_SORT_CMP;
        end
        S_SORT_CMP: begin
          if (cand) begin
            best_key  <= key_i;
            best_idx  <= idx;
            have_best <= 1'b1;
          end
          if (last_idx) begin
            state <= S_SORT_NEXT;
          end else begin
            idx   <= idx + ADDR_W'(1);
            state <= S_SORT_RD;
          end
        end
        S_SORT_NEXT: begin
          top[r]    <= best_idx;
          prev_key  <= best_key;
          have_best <= 1'b0;
          idx       <= '0;
          if (({1'b0, r} + (RANK_W+1)'(1)) == nsel) begin
            sorted <= 1'b1;
            state  <= S_IDLE;
          end else begin
            r     <= r + RANK_W'(1);
            state <= S_SORT_RD;
          end
        end
        // Present the read result with a one-cycle done pulse
        S_RD_OUT: begin
          done           <= 1'b1;
          valid_res      <= rd_ok;
          distinct_words <= distinct;
          entry_count    <= rd_ok ? rdata.count : '0;
          entry_length   <= rd_ok ? rdata.len : '0;
          if (rd_ok && ({1'b0, rd_pos} < rdata.len)) begin
            entry_byte <= rdata.bytes[(WORD_BYTES-1-rd_pos)*8 +: 8];
          end else begin
            entry_byte <= '0;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import wft_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [1:0] op = OP_BYTE;
  logic [7:0] text_byte = '0;
  logic [3:0] rank = '0;
  logic [3:0] char_pos = '0;
  logic       busy, done, valid_res;
  logic [8:0] distinct_words, entry_count;
  logic [4:0] entry_length;
  logic [7:0] entry_byte;

  word_frequency_top_k i_dut (
    .clk, .rst, .start, .busy, .op, .text_byte, .rank, .char_pos,
    .done, .valid_res, .distinct_words, .entry_count, .entry_length, .entry_byte
  );

  always #1 clk = ~clk;

  typedef struct {
    logic       ok;
    logic [8:0] distinct;
    logic [8:0] count;
    logic [4:0] length;
    logic [7:0] ch;
  } entry_view_t;

  typedef enum logic {COLLECTING, SORTED} phase_e;

  // Mirror of the block's word store
  logic [7:0] pend_word [WORD_BYTES];
  int         pend_len;
  logic [7:0] word_bytes [TABLE_WORDS][WORD_BYTES];
  int         word_len [TABLE_WORDS];
  int         word_cnt [TABLE_WORDS];
  int         ranked [TABLE_WORDS];
  int         n_distinct, n_taken;
  phase_e     phase;

  entry_view_t pending_views[$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic void wipe_store();
    pend_len = 0; n_distinct = 0; n_taken = 0; phase = COLLECTING;
  endfunction

  function automatic void close_word();
    int i;
    bit hit;
    if (pend_len == 0) return;
    if (n_taken < TABLE_WORDS) begin
      n_taken++;
      hit = 0;
      for (i = 0; i < n_distinct && !hit; i++) begin
        if (word_len[i] == pend_len) begin
          hit = 1;
          for (int k = 0; k < pend_len; k++)
            if (word_bytes[i][k] != pend_word[k]) hit = 0;
          if (hit) word_cnt[i]++;
        end
      end
      if (!hit && n_distinct < TABLE_WORDS) begin
        for (int k = 0; k < WORD_BYTES; k++)
          word_bytes[n_distinct][k] = (k < pend_len) ? pend_word[k] : 8'h00;
        word_len[n_distinct] = pend_len;
        word_cnt[n_distinct] = 1;
        n_distinct++;
      end
    end
    pend_len = 0;
  endfunction

  function automatic bit outranks(int a, int b);
    if (word_cnt[a] != word_cnt[b]) return word_cnt[a] > word_cnt[b];
    for (int k = 0; k < WORD_BYTES; k++)
      if (word_bytes[a][k] != word_bytes[b][k]) return word_bytes[a][k] < word_bytes[b][k];
    if (word_len[a] != word_len[b]) return word_len[a] < word_len[b];
    return a < b;
  endfunction

  function automatic void rank_words();
    int j, key;
    for (int i = 0; i < n_distinct; i++) ranked[i] = i;
    for (int i = 1; i < n_distinct; i++) begin
      key = ranked[i];
      j = i;
      while (j > 0 && outranks(key, ranked[j-1])) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = key;
    end
    phase = SORTED;
  endfunction

  // Advance the mirror by one command; return 1 with the view when a read answers
  function automatic bit predict_entry(logic [1:0] o, logic [7:0] c, logic [3:0] r,
                                       logic [3:0] p, output entry_view_t v);
    int e;
    v = '{0, 0, 0, 0, 0};
    case (o)
      OP_BYTE: begin
        if (c == CH_NEWLINE) begin
          close_word(); rank_words();
        end else begin
          phase = COLLECTING;
          if (c == CH_SPACE) close_word();
          else if (pend_len < WORD_BYTES) begin
            pend_word[pend_len] = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
            pend_len++;
          end
        end
        return 0;
      end
      OP_END: begin
        close_word(); rank_words(); return 0;
      end
      OP_CLEAR: begin
        wipe_store(); return 0;
      end
      default: begin
        v.distinct = n_distinct[8:0];
        if (phase == SORTED && r < n_distinct && r < TOP_RANKS) begin
          e = ranked[r];
          v.ok = 1;
          v.count = word_cnt[e][8:0];
          v.length = word_len[e][4:0];
          if (p < word_len[e]) v.ch = word_bytes[e][p];
        end
        return 1;
      end
    endcase
  endfunction

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    entry_view_t w;
    if (!rst && done) begin
      if (pending_views.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        w = pending_views.pop_front();
        if (valid_res !== w.ok) begin
          $error("valid_res exp %0d got %0d", w.ok, valid_res); errors++;
        end
        if (distinct_words !== w.distinct) begin
          $error("distinct_words exp %0d got %0d", w.distinct, distinct_words); errors++;
        end
        if (entry_count !== w.count) begin
          $error("entry_count exp %0d got %0d", w.count, entry_count); errors++;
        end
        if (entry_length !== w.length) begin
          $error("entry_length exp %0d got %0d", w.length, entry_length); errors++;
        end
        if (entry_byte !== w.ch) begin
          $error("entry_byte exp %0h got %0h", w.ch, entry_byte); errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 200000) begin
      $display("word_frequency_top_k test failed");
      $finish;
    end
  end

  int gap_left = 0;
  int burst_left = 0;
  bit paused = 0;

  // Drive one command and hold it until accepted; gaps follow the burst pattern.
  // Start stays high after acceptance so the next command can follow back to back.
  task automatic send(logic [1:0] o, logic [7:0] c, logic [3:0] r, logic [3:0] p,
                      bit chk = 0, entry_view_t typed = '{0, 0, 0, 0, 0});
    entry_view_t v;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    end
    if (gap_left > 0) begin
      start <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    burst_left--;
    start <= 1'b1; op <= o; text_byte <= c; rank <= r; char_pos <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (predict_entry(o, c, r, p, v)) begin
      if (chk && v != typed) begin
        $error("predictor disagrees with typed row: rank %0d", r); errors++;
      end
      pending_views.push_back(v);
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send(OP_BYTE, s[i], 0, 0);
  endtask

  // Random byte, mostly letters from a small alphabet so words repeat
  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 255));
      1, 2: return 8'($urandom_range(8'h41, 8'h43));
      default: return 8'($urandom_range(8'h61, 8'h64));
    endcase
  endfunction

  int sent = 0;
  int n, wl;

  initial begin
    wipe_store();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part
    send(OP_READ, 0, 0, 0, 1, '{0, 0, 0, 0, 0});
    send_text("Hi  hi  ZZ");
    send(OP_BYTE, 8'h00, 0, 0);
    send(OP_BYTE, 8'hFF, 0, 0);
    send_text(" abcdefghijklmnopqrstu ");
    send(OP_END, 0, 0, 0);
    send(OP_READ, 0, 0, 0, 1, '{1, 3, 2, 2, 8'h68});
    send(OP_READ, 0, 4'd15, 4'd15);
    send(OP_READ, 0, 4'd1, 4'd15);
    send(OP_READ, 0, 4'd2, 4'd15);
    send(OP_END, 0, 0, 0);
    send(OP_READ, 0, 4'd2, 4'd2);
    send(OP_BYTE, 8'h61, 0, 0);
    send(OP_READ, 0, 0, 0);
    send(OP_BYTE, CH_NEWLINE, 0, 0);
    send(OP_READ, 0, 4'd1, 0);
    send(OP_CLEAR, 0, 0, 0);
    send(OP_READ, 0, 0, 0, 1, '{0, 0, 0, 0, 0});
    sent = 49;

    // Random part: mostly well-formed texts, then reads of the ranking
    while (sent < 1900) begin
      n = $urandom_range(1, 30);
      if ($urandom_range(0, 7) == 0) n = $urandom_range(200, 300);
      for (int w = 0; w < n && sent < 1900; w++) begin
        wl = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 3);
        for (int k = 0; k < wl; k++) begin
          send(OP_BYTE, word_char(), 0, 0); sent++;
        end
        repeat ($urandom_range(1, 2)) begin
          send(OP_BYTE, CH_SPACE, 0, 0); sent++;
        end
      end
      if ($urandom_range(0, 1)) send(OP_END, 0, 0, 0);
      else send(OP_BYTE, CH_NEWLINE, 0, 0);
      sent++;
      repeat ($urandom_range(5, 25)) begin
        send(OP_READ, 0, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        sent++;
      end
      // Occasional noise: a stray byte and then a read while collecting
      if ($urandom_range(0, 3) == 0) begin
        send(OP_BYTE, word_char(), 0, 0);
        send(OP_READ, 0, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        sent += 2;
      end
      if (sent > 900 && !paused) begin
        // Hold off until every read has answered
        paused = 1;
        if (pending_views.size() != 0) begin
          start <= 1'b0;
          while (pending_views.size() != 0) @(posedge clk);
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        send(OP_CLEAR, 0, 0, 0); sent++;
      end
    end

    // Drain outstanding results
    start <= 1'b0;
    n = 0;
    while (pending_views.size() != 0 && n < 100000) begin
      @(posedge clk); n++;
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_views.size() == 0) begin
      $display("word_frequency_top_k test passed");
    end else begin
      $display("word_frequency_top_k test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
